/* rtl/core/four_char_word_machine_executor_core_assert.svh */
// assertion macros for the word machine core
`ifndef FOUR_CHAR_WORD_MACHINE_EXECUTOR_CORE_ASSERT_SVH
`define FOUR_CHAR_WORD_MACHINE_EXECUTOR_CORE_ASSERT_SVH

// condition that must hold at every edge out of reset
`define FCW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication property checked at every edge out of reset
`define FCW_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* rtl/core/fcw_pkg.sv */
package fcw_pkg;

  localparam int DATA_LINES_DEF = 16;
  localparam int LINE_CHARS_DEF = 40;
  localparam int NWORDS = 100;
  localparam int NBYTES = 400;

  localparam logic [7:0]  STAR   = 8'h2A;
  localparam logic [31:0] STARS  = 32'h2A2A2A2A;
  localparam logic [7:0]  CH_0   = 8'h30;
  localparam logic [7:0]  CH_NL  = 8'h0A;
  localparam logic [7:0]  CH_B   = 8'h42;
  localparam logic [7:0]  CH_C   = 8'h43;
  localparam logic [7:0]  CH_D   = 8'h44;
  localparam logic [7:0]  CH_G   = 8'h47;
  localparam logic [7:0]  CH_H   = 8'h48;
  localparam logic [7:0]  CH_L   = 8'h4C;
  localparam logic [7:0]  CH_P   = 8'h50;
  localparam logic [7:0]  CH_R   = 8'h52;
  localparam logic [7:0]  CH_S   = 8'h53;
  localparam logic [7:0]  CH_T   = 8'h54;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_DCHAR = 3'd2,
    CMD_ENDL  = 3'd3,
    CMD_EXEC  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    K_OK       = 3'd0,
    K_CHAR     = 3'd1,
    K_LINE_END = 3'd2,
    K_HALTED   = 3'd3,
    K_RAN_OFF  = 3'd4,
    K_BAD_ADDR = 3'd5,
    K_DROPPED  = 3'd6
  } kind_t;

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
    return w[8*(3-k) +: 8];
  endfunction

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] k,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = w;
    r[8*(3-k) +: 8] = v;
    return r;
  endfunction

  // bytes after the first zero byte become zero
  function automatic logic [31:0] bounded(input logic [31:0] w);
    logic [31:0] r;
    logic z;
    r = '0;
    z = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!z) r[8*(3-k) +: 8] = w[8*(3-k) +: 8];
      if (w[8*(3-k) +: 8] == 8'h00) z = 1'b1;
    end
    return r;
  endfunction

  // equal up to and including the first zero byte
  function automatic logic same_bounded(input logic [31:0] a, input logic [31:0] b);
    logic res;
    logic done;
    res = 1'b1;
    done = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!done) begin
        if (a[8*(3-k) +: 8] != b[8*(3-k) +: 8]) begin
          res = 1'b0;
          done = 1'b1;
        end else if (a[8*(3-k) +: 8] == 8'h00) begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/fcw_if.sv */
interface fcw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [6:0]  load_addr;
  logic [31:0] load_word;
  logic [7:0]  data_char;

  modport source(output valid, cmd, load_addr, load_word, data_char, input ready);
  modport sink(input valid, cmd, load_addr, load_word, data_char, output ready);
endinterface

interface fcw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_char;
  logic [6:0] next_ic;
  logic       cond;
  logic       last;

  modport source(output valid, kind, out_char, next_ic, cond, last, input ready);
  modport sink(input valid, kind, out_char, next_ic, cond, last, output ready);
endinterface

/* rtl/core/fcw_ram.sv */
module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* rtl/core/four_char_word_machine_executor_core.sv */
// Word machine core: 100 words of four characters in a one-port-read, one-port-write RAM
// (unwritten words read as '*' through per-word valid bits, so clear need not write the
// RAM), plus RAMs for data-card characters and line lengths. Clear, load, data char and
// end line are taken in the idle state and answered from the result state. Execute goes
// through fetch read, decode and result, with a second memory read for LR and CR. GD
// reads the line length, then reads and writes back the target word for each copied
// character, with one more read when a zero or newline ends the copy. PD reads each word
// and sends its characters other than '*' one at a time, stalling while the result side
// is not ready. The next item is taken once the last result is in the output register.
`include "four_char_word_machine_executor_core_assert.svh"

module four_char_word_machine_executor_core #(
  parameter int DATA_LINES = fcw_pkg::DATA_LINES_DEF,
  parameter int LINE_CHARS = fcw_pkg::LINE_CHARS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  fcw_in_if.sink  req,
  fcw_out_if.source rsp
);
  import fcw_pkg::*;

  localparam int LINE_W = (DATA_LINES > 1) ? $clog2(DATA_LINES) : 1;
  localparam int CNT_W = $clog2(DATA_LINES + 1);
  localparam int POS_W = $clog2(LINE_CHARS + 1);
  localparam int DS_DEPTH = DATA_LINES * LINE_CHARS;
  localparam int DS_AW = $clog2(DS_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_DEC, S_LR, S_CR, S_GD_LEN, S_GD_RD, S_GD_WR,
    S_PD_RD, S_PD_GET, S_PD_CH
  } state_t;

  state_t state;
  kind_t res_kind;

  logic [NWORDS-1:0] mvld;
  logic              mem_rvld;
  logic [CNT_W-1:0]  dlc;
  logic [CNT_W-1:0]  drl;
  logic [POS_W-1:0]  fp;
  logic [31:0]       greg;
  logic              cond;
  logic [6:0]        ic;
  logic              halted;

  logic [DS_AW-1:0]  line_base;
  logic [POS_W-1:0]  gpos;
  logic [POS_W-1:0]  glen;
  logic [8:0]        gb;
  logic [6:0]        pa;
  logic [3:0]        pi;
  logic [1:0]        pk;
  logic [31:0]       pword;

  logic              out_valid;
  logic [2:0]        out_kind;
  logic [7:0]        out_char;
  logic [6:0]        out_ic;
  logic              out_cond;
  logic              out_last;

  logic              mem_we, mem_re;
  logic [6:0]        mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;
  logic              ds_we, ds_re;
  logic [DS_AW-1:0]  ds_waddr, ds_raddr;
  logic [7:0]        ds_rdata;
  logic              ll_we, ll_re;
  logic [LINE_W-1:0] ll_waddr, ll_raddr;
  logic [POS_W-1:0]  ll_rdata;

  logic        acc;
  logic        slot_free;
  cmd_t        cmd;
  logic [31:0] word_rd;
  logic [31:0] ir;
  logic [7:0]  op0, op1, d1, d2;
  logic        ok;
  logic [6:0]  daddr;
  logic [7:0]  pch;
  logic [7:0]  gch;
  logic        gd_more;
  logic        is_gd, is_pd, is_lr, is_sr, is_cr, is_bt;

  assign req.ready = (state == S_IDLE);
  assign acc = req.valid && req.ready;
  assign cmd = cmd_t'(req.cmd);
  assign slot_free = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.kind = out_kind;
  assign rsp.out_char = out_char;
  assign rsp.next_ic = out_ic;
  assign rsp.cond = out_cond;
  assign rsp.last = out_last;

  assign word_rd = mem_rvld ? mem_rdata : STARS;
  assign ir = bounded(word_rd);
  assign op0 = ir[31:24];
  assign op1 = ir[23:16];
  assign d1 = ir[15:8] - CH_0;
  assign d2 = ir[7:0] - CH_0;
  assign ok = (d1 < 8'd10) && (d2 < 8'd10);
  assign daddr = 7'(d1[3:0]) * 7'd10 + 7'(d2[3:0]);
  assign is_gd = (op0 == CH_G) && (op1 == CH_D);
  assign is_pd = (op0 == CH_P) && (op1 == CH_D);
  assign is_lr = (op0 == CH_L) && (op1 == CH_R);
  assign is_sr = (op0 == CH_S) && (op1 == CH_R);
  assign is_cr = (op0 == CH_C) && (op1 == CH_R);
  assign is_bt = (op0 == CH_B) && (op1 == CH_T);
  assign pch = byte_of(pword, pk);
  assign gch = ds_rdata;
  assign gd_more = (gb < 9'(NBYTES)) && (gpos < glen) && (gpos < POS_W'(LINE_CHARS));

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = '0;
    ds_we = 1'b0;
    ds_waddr = DS_AW'(int'(dlc[LINE_W-1:0]) * LINE_CHARS + int'(fp));
    ds_re = 1'b0;
    ds_raddr = line_base + DS_AW'(gpos);
    ll_we = 1'b0;
    ll_waddr = dlc[LINE_W-1:0];
    ll_re = 1'b0;
    ll_raddr = drl[LINE_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (acc && cmd == CMD_LOAD && req.load_addr < 7'(NWORDS)) begin
          mem_we = 1'b1;
          mem_waddr = req.load_addr;
          mem_wdata = bounded(req.load_word);
        end
        if (acc && cmd == CMD_EXEC && !halted && ic < 7'(NWORDS)) begin
          mem_re = 1'b1;
          mem_raddr = ic;
        end
        if (acc && cmd == CMD_DCHAR && dlc < CNT_W'(DATA_LINES)
            && fp < POS_W'(LINE_CHARS)) begin
          ds_we = 1'b1;
        end
        if (acc && cmd == CMD_ENDL && dlc < CNT_W'(DATA_LINES)) ll_we = 1'b1;
      end
      S_DEC: begin
        if (ok && is_sr) begin
          mem_we = 1'b1;
          mem_waddr = daddr;
          mem_wdata = bounded(greg);
        end
        if (ok && (is_lr || is_cr)) begin
          mem_re = 1'b1;
          mem_raddr = daddr;
        end
        if (ok && is_gd) ll_re = 1'b1;
      end
      S_GD_RD: begin
        if (gd_more) begin
          mem_re = 1'b1;
          mem_raddr = gb[8:2];
          ds_re = 1'b1;
        end
      end
      S_GD_WR: begin
        if (gch != 8'h00 && gch != CH_NL) begin
          mem_we = 1'b1;
          mem_waddr = gb[8:2];
          mem_wdata = put_byte(word_rd, gb[1:0], gch);
        end
      end
      S_PD_RD: begin
        if (pi < 4'd10 && pa < 7'(NWORDS)) begin
          mem_re = 1'b1;
          mem_raddr = pa;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_kind <= K_OK;
      mvld <= '0;
      mem_rvld <= 1'b0;
      dlc <= '0;
      drl <= '0;
      fp <= '0;
      greg <= STARS;
      cond <= 1'b0;
      ic <= '0;
      halted <= 1'b0;
      out_valid <= 1'b0;
      out_kind <= K_OK;
      out_char <= '0;
      out_ic <= '0;
      out_cond <= 1'b0;
      out_last <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      if (mem_re) mem_rvld <= mvld[mem_raddr];
      if (mem_we) mvld[mem_waddr] <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            state <= S_EMIT;
            res_kind <= K_OK;
            unique case (cmd)
              CMD_CLEAR: begin
                mvld <= '0;
                dlc <= '0;
                drl <= '0;
                fp <= '0;
                greg <= STARS;
                cond <= 1'b0;
                ic <= '0;
                halted <= 1'b0;
              end
              CMD_LOAD: begin
                if (req.load_addr >= 7'(NWORDS)) res_kind <= K_BAD_ADDR;
              end
              CMD_DCHAR: begin
                if (dlc < CNT_W'(DATA_LINES) && fp < POS_W'(LINE_CHARS)) begin
                  fp <= fp + 1'b1;
                end else begin
                  res_kind <= K_DROPPED;
                end
              end
              CMD_ENDL: begin
                fp <= '0;
                if (dlc < CNT_W'(DATA_LINES)) dlc <= dlc + 1'b1;
                else res_kind <= K_DROPPED;
              end
              CMD_EXEC: begin
                if (halted) res_kind <= K_HALTED;
                else if (ic >= 7'(NWORDS)) res_kind <= K_RAN_OFF;
                else state <= S_DEC;
              end
              default: begin
              end
            endcase
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind <= res_kind;
            out_char <= '0;
            out_ic <= ic;
            out_cond <= cond;
            out_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DEC: begin
          ic <= ic + 1'b1;
          state <= S_EMIT;
          res_kind <= K_OK;
          priority if (is_gd) begin
            if (!ok) begin
              res_kind <= K_BAD_ADDR;
            end else if (drl < dlc && drl < CNT_W'(DATA_LINES)) begin
              line_base <= DS_AW'(int'(drl[LINE_W-1:0]) * LINE_CHARS);
              drl <= drl + 1'b1;
              gb <= {daddr, 2'b00};
              gpos <= '0;
              state <= S_GD_LEN;
            end
          end else if (is_pd) begin
            if (!ok) begin
              res_kind <= K_BAD_ADDR;
            end else begin
              pa <= daddr;
              pi <= '0;
              state <= S_PD_RD;
            end
          end else if (is_lr) begin
            if (!ok) res_kind <= K_BAD_ADDR;
            else state <= S_LR;
          end else if (is_sr) begin
            if (!ok) res_kind <= K_BAD_ADDR;
          end else if (is_cr) begin
            if (!ok) res_kind <= K_BAD_ADDR;
            else state <= S_CR;
          end else if (is_bt) begin
            if (cond) begin
              if (!ok) res_kind <= K_BAD_ADDR;
              else ic <= daddr;
            end
          end else if (op0 == CH_H) begin
            halted <= 1'b1;
            res_kind <= K_HALTED;
          end else begin
            res_kind <= K_OK;
          end
        end
        S_LR: begin
          greg <= bounded(word_rd);
          state <= S_EMIT;
        end
        S_CR: begin
          cond <= same_bounded(greg, word_rd);
          state <= S_EMIT;
        end
        S_GD_LEN: begin
          glen <= ll_rdata;
          state <= S_GD_RD;
        end
        S_GD_RD: begin
          if (gd_more) state <= S_GD_WR;
          else state <= S_EMIT;
        end
        S_GD_WR: begin
          if (gch == 8'h00 || gch == CH_NL) begin
            state <= S_EMIT;
          end else begin
            gb <= gb + 1'b1;
            gpos <= gpos + 1'b1;
            state <= S_GD_RD;
          end
        end
        S_PD_RD: begin
          if (pi < 4'd10 && pa < 7'(NWORDS)) begin
            state <= S_PD_GET;
          end else begin
            res_kind <= K_LINE_END;
            state <= S_EMIT;
          end
        end
        S_PD_GET: begin
          pword <= word_rd;
          pk <= '0;
          state <= S_PD_CH;
        end
        S_PD_CH: begin
          if (pch == STAR || slot_free) begin
            if (pch != STAR) begin
              out_valid <= 1'b1;
              out_kind <= K_CHAR;
              out_char <= pch;
              out_ic <= ic;
              out_cond <= cond;
              out_last <= 1'b0;
            end
            if (pk == 2'd3) begin
              pi <= pi + 1'b1;
              pa <= pa + 1'b1;
              state <= S_PD_RD;
            end else begin
              pk <= pk + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fcw_ram #(.WIDTH(32), .DEPTH(NWORDS)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  fcw_ram #(.WIDTH(8), .DEPTH(DS_DEPTH)) u_data_store (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(req.data_char),
    .re(ds_re), .raddr(ds_raddr), .rdata(ds_rdata)
  );

  fcw_ram #(.WIDTH(POS_W), .DEPTH(DATA_LINES)) u_line_len (
    .clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(fp),
    .re(ll_re), .raddr(ll_raddr), .rdata(ll_rdata)
  );

  `FCW_ASSERT_PROP(a_no_rw_clash, ((mem_we && mem_re) |-> (mem_waddr != mem_raddr)), "main memory read and write hit the same word")
  `FCW_ASSERT_ALWAYS(a_read_le_count, (drl <= dlc), "read line passed the closed line count")
  `FCW_ASSERT_ALWAYS(a_ic_range, (ic <= 7'(NWORDS)), "instruction counter out of range")
  `FCW_ASSERT_PROP(a_halt_holds_ic, ((halted && !(acc && cmd == CMD_CLEAR)) |=> $stable(ic)), "instruction counter moved while halted")

endmodule
